// ===== rtl/core/sto_pkg.sv =====
package sto_pkg;

  // Fixed field widths
  localparam int NODE_W  = 6;
  localparam int COUNT_W = 7;
  localparam int EDGE_W  = 2 * NODE_W;

  localparam logic [COUNT_W-1:0] NODES_RESET = 7'd64;

  // Item mode codes
  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_RUN = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] consumer_node;
  } item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic              from_cycle;
    logic              edges_dropped;
    logic              last;
  } result_t;

  // Node walk kinds
  typedef enum logic [1:0] {
    WALK_CLEAR,
    WALK_SEED,
    WALK_LEFT
  } walk_op_t;

  // Edge scan kinds
  typedef enum logic {
    SCAN_COUNT,
    SCAN_DEC
  } scan_op_t;

  typedef struct packed {
    logic     load_edge;
    logic     run_clear;
    logic     walk_start;
    walk_op_t walk_op;
    logic     scan_start;
    scan_op_t scan_op;
    logic     pop;
    logic     emit_pop;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic walk_busy;
    logic scan_busy;
    logic queue_empty;
  } status_t;

endpackage

// ===== rtl/core/sto_ctrl.sv =====
module sto_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            mode,
  input  sto_pkg::status_t status,
  output logic            busy,
  output sto_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_COUNT,
    ST_SEED,
    ST_POP,
    ST_EMIT,
    ST_SCAN,
    ST_LEFT,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // Command decode and next state
  always_comb begin
    cmd        = '0;
    cmd.walk_op = sto_pkg::WALK_CLEAR;
    cmd.scan_op = sto_pkg::SCAN_COUNT;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (mode == sto_pkg::MODE_ADD) begin
            cmd.load_edge = 1'b1;
          end else if (status.n_zero) begin
            cmd.run_clear = 1'b1;
          end else begin
            cmd.walk_start = 1'b1;
            cmd.walk_op    = sto_pkg::WALK_CLEAR;
            state_next     = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        if (!status.walk_busy) begin
          cmd.scan_start = 1'b1;
          cmd.scan_op    = sto_pkg::SCAN_COUNT;
          state_next     = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (!status.scan_busy) begin
          cmd.walk_start = 1'b1;
          cmd.walk_op    = sto_pkg::WALK_SEED;
          state_next     = ST_SEED;
        end
      end
      ST_SEED: begin
        if (!status.walk_busy) begin
          state_next = ST_POP;
        end
      end
      ST_POP: begin
        if (status.queue_empty) begin
          cmd.walk_start = 1'b1;
          cmd.walk_op    = sto_pkg::WALK_LEFT;
          state_next     = ST_LEFT;
        end else begin
          cmd.pop    = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit_pop   = 1'b1;
        cmd.scan_start = 1'b1;
        cmd.scan_op    = sto_pkg::SCAN_DEC;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        if (!status.scan_busy) begin
          state_next = ST_POP;
        end
      end
      ST_LEFT: begin
        if (!status.walk_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.run_clear = 1'b1;
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

`ifndef SYNTHESIS
  // busy tracks the state register
  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != ST_IDLE))
    else $error("busy out of step with state");

  // an emit is always followed by a decrement scan
  a_emit_scan: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |=> state == ST_SCAN)
    else $error("emit not followed by scan");

  // a pop only follows a drained scan or seed pass
  a_pop_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_POP) |-> $past(state) == ST_SEED || $past(state) == ST_SCAN)
    else $error("pop entered from wrong phase");
`endif

endmodule

// ===== rtl/core/sto_datapath.sv =====
module sto_datapath #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [sto_pkg::COUNT_W-1:0]       cfg_data,
  input  sto_pkg::item_t                    item,
  input  sto_pkg::cmd_t                     cmd,
  output sto_pkg::status_t                  status,
  output logic                              strobe,
  output sto_pkg::result_t                  result
);

  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int TW = $clog2(MAX_EDGES + 1);
  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int NDW = sto_pkg::NODE_W;

  // Configuration and clamped node count
  logic [sto_pkg::COUNT_W-1:0] nodes_cfg;
  logic [CW-1:0]               n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_cfg <= sto_pkg::NODES_RESET;
    end else if (cfg_write) begin
      nodes_cfg <= cfg_data;
    end
  end

  assign n_eff = (nodes_cfg > sto_pkg::COUNT_W'(MAX_NODES)) ? CW'(MAX_NODES)
                                                            : CW'(nodes_cfg);

  // Edge store
  logic [sto_pkg::EDGE_W-1:0] edge_mem [MAX_EDGES];
  logic [TW-1:0]              edge_total;
  logic                       overflow;
  logic [sto_pkg::EDGE_W-1:0] edge_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total <= '0;
      overflow   <= 1'b0;
    end else if (cmd.run_clear) begin
      edge_total <= '0;
      overflow   <= 1'b0;
    end else if (cmd.load_edge) begin
      if (edge_total < TW'(MAX_EDGES)) begin
        edge_total <= edge_total + TW'(1);
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_edge && edge_total < TW'(MAX_EDGES)) begin
      edge_mem[edge_total[EW-1:0]] <= {item.source_node, item.consumer_node};
    end
  end

  // Edge scan: address stage, edge data stage, in-degree update stage
  logic           scan_active;
  logic [TW-1:0]  scan_idx;
  logic           scan_dec;
  logic           p1_valid;
  logic           p2_valid;
  logic [NW-1:0]  p2_addr;
  logic [NDW-1:0] p1_src;
  logic [NDW-1:0] p1_cons;
  logic           p1_ok;
  logic           p1_hit;
  logic [NDW-1:0] q_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
      p1_valid    <= 1'b0;
      p2_valid    <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scan_active <= (edge_total != '0);
      end else if (scan_active && (scan_idx + TW'(1) == edge_total)) begin
        scan_active <= 1'b0;
      end
      p1_valid <= scan_active;
      p2_valid <= p1_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
      scan_dec <= (cmd.scan_op == sto_pkg::SCAN_DEC);
    end else if (scan_active) begin
      scan_idx <= scan_idx + TW'(1);
    end
    if (scan_active) begin
      edge_rd <= edge_mem[scan_idx[EW-1:0]];
    end
    p2_addr <= p1_cons[NW-1:0];
  end

  // Edge check against the current node count and for self-loops; a decrement scan also needs the dequeued source
  assign p1_src  = edge_rd[sto_pkg::EDGE_W-1:NDW];
  assign p1_cons = edge_rd[NDW-1:0];
  assign p1_ok   = (sto_pkg::COUNT_W'(p1_src) < sto_pkg::COUNT_W'(n_eff)) &&
                   (sto_pkg::COUNT_W'(p1_cons) < sto_pkg::COUNT_W'(n_eff)) &&
                   (p1_src != p1_cons);
  assign p1_hit  = p1_valid && p1_ok && (!scan_dec || p1_src == q_rd);

  // Node walk over 0 .. n-1
  logic                walk_active;
  logic [CW-1:0]       node_idx;
  sto_pkg::walk_op_t   walk_op;
  logic                rdv;
  logic [NDW-1:0]      rd_node;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_active <= 1'b0;
      rdv         <= 1'b0;
    end else begin
      if (cmd.walk_start) begin
        walk_active <= 1'b1;
      end else if (walk_active && (node_idx + CW'(1) == n_eff)) begin
        walk_active <= 1'b0;
      end
      rdv <= walk_active && (walk_op != sto_pkg::WALK_CLEAR);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      node_idx <= '0;
      walk_op  <= cmd.walk_op;
    end else if (walk_active) begin
      node_idx <= node_idx + CW'(1);
    end
    rd_node <= NDW'(node_idx[NW-1:0]);
  end

  // In-degree memory with a bypass of the latest write
  logic [TW-1:0] deg_mem [MAX_NODES];
  logic [TW-1:0] deg_rd;
  logic [NW-1:0] deg_rd_addr;
  logic          deg_we;
  logic [NW-1:0] deg_wr_addr;
  logic [TW-1:0] deg_wr_data;
  logic          byp_valid;
  logic [NW-1:0] byp_addr;
  logic [TW-1:0] byp_data;
  logic [TW-1:0] deg_cur;
  logic          clear_we;
  logic          upd_we;
  logic [TW-1:0] upd_data;
  logic          dec_push;

  assign deg_rd_addr = p1_valid ? p1_cons[NW-1:0] : node_idx[NW-1:0];
  assign deg_cur     = (byp_valid && byp_addr == p2_addr) ? byp_data : deg_rd;
  assign clear_we    = walk_active && (walk_op == sto_pkg::WALK_CLEAR);

  always_comb begin
    if (scan_dec) begin
      upd_we   = p2_valid && (deg_cur != '0);
      upd_data = deg_cur - TW'(1);
    end else begin
      upd_we   = p2_valid;
      upd_data = deg_cur + TW'(1);
    end
  end

  assign dec_push    = scan_dec && upd_we && (upd_data == '0);
  assign deg_we      = clear_we || upd_we;
  assign deg_wr_addr = clear_we ? node_idx[NW-1:0] : p2_addr;
  assign deg_wr_data = clear_we ? '0 : upd_data;

  always_ff @(posedge clk) begin
    deg_rd <= deg_mem[deg_rd_addr];
    if (deg_we) begin
      deg_mem[deg_wr_addr] <= deg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (deg_we) begin
      byp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      byp_addr <= deg_wr_addr;
      byp_data <= deg_wr_data;
    end
  end

  // Ready queue
  logic [NDW-1:0] q_mem [MAX_NODES];
  logic [CW-1:0]  head;
  logic [CW-1:0]  tail;
  logic           seed_push;
  logic           push;
  logic [NDW-1:0] push_node;

  assign seed_push = rdv && (walk_op == sto_pkg::WALK_SEED) && (deg_rd == '0);
  assign push      = seed_push || dec_push;
  assign push_node = seed_push ? rd_node : NDW'(p2_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (cmd.walk_start && cmd.walk_op == sto_pkg::WALK_SEED) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (push) begin
        tail <= tail + CW'(1);
      end
      if (cmd.pop) begin
        head <= head + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[tail[NW-1:0]] <= push_node;
    end
    if (cmd.pop) begin
      q_rd <= q_mem[head[NW-1:0]];
    end
  end

  // Result register
  logic          left_emit;
  logic          emit_now;
  logic [CW-1:0] emit_cnt;

  assign left_emit = rdv && (walk_op == sto_pkg::WALK_LEFT) && (deg_rd != '0);
  assign emit_now  = cmd.emit_pop || left_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe   <= 1'b0;
      emit_cnt <= '0;
    end else begin
      strobe <= emit_now;
      if (cmd.walk_start && cmd.walk_op == sto_pkg::WALK_CLEAR) begin
        emit_cnt <= '0;
      end else if (emit_now) begin
        emit_cnt <= emit_cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      result.node_index    <= cmd.emit_pop ? q_rd : rd_node;
      result.from_cycle    <= !cmd.emit_pop;
      result.edges_dropped <= overflow;
      result.last          <= (emit_cnt + CW'(1) == n_eff);
    end
  end

  // Status to the controller
  assign status.n_zero      = (n_eff == '0);
  assign status.walk_busy   = walk_active || rdv;
  assign status.scan_busy   = scan_active || p1_valid || p2_valid;
  assign status.queue_empty = (head == tail);

`ifndef SYNTHESIS
  // a scan only starts once the previous one has drained
  a_scan_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |-> !scan_active && !p1_valid && !p2_valid)
    else $error("scan started while busy");

  // a walk only starts once the previous one has drained
  a_walk_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_start |-> !walk_active && !rdv)
    else $error("walk started while busy");

  // queue pointers stay ordered and within depth
  a_queue_bounds: assert property (@(posedge clk) disable iff (rst)
    head <= tail && tail <= CW'(MAX_NODES))
    else $error("ready queue pointers out of range");

  // nothing follows the final beat of an order
  a_last_quiet: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe)
    else $error("beat after last");
`endif

endmodule

// ===== rtl/core/stable_topological_order.sv =====
// Channel  | Ports                        | Handshake
// ---------+------------------------------+-----------------------------------
// item     | start, busy, item            | beat taken when start && !busy
// result   | strobe, result               | one-cycle beat, no backpressure
// config   | cfg_write, cfg_data          | node count written when cfg_write
//
// An edge item is stored without raising busy. For a run item, busy stays high through
// a clear pass over the nodes, a count pass over the stored edges, a seed pass, one
// edge-store pass per dequeued node, a final pop, a leftovers pass and a finish state;
// the edge store has a single read port and is walked once per dequeued node.
// A run with a node count of zero emits nothing and keeps busy low.
// Reset (rst, synchronous) empties the edge store and sets the node count to 64.
// The receiver cannot stall: each result beat is on the ports for exactly one cycle.
module stable_topological_order #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  sto_pkg::item_t              item,
  output logic                        strobe,
  output sto_pkg::result_t            result,
  input  logic                        cfg_write,
  input  logic [sto_pkg::COUNT_W-1:0] cfg_data
);

  sto_pkg::cmd_t    cmd;
  sto_pkg::status_t status;
  logic             accept;

  // Items are only seen by the controller when the block is free
  assign accept = start && !busy;

  sto_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .mode   (item.mode),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  sto_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .strobe    (strobe),
    .result    (result)
  );

endmodule
